// ===== hdl/msec_pkg.sv =====
// Shared types and constants for the MIPS-subset execute core.
// Opcode and funct codes, data store geometry, inter-module structs.
// No dependencies.
package msec_pkg;

   // Data store depth in words; must be a power of two (word index is masked).
   localparam int unsigned DATA_WORDS = 1024;
   localparam int unsigned DSTORE_AW  = $clog2(DATA_WORDS);

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BASE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_LENGTH = 1'b1;

   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ANDI  = 6'h0c;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2b;

   localparam logic [5:0] FN_SLL = 6'h00;
   localparam logic [5:0] FN_SRL = 6'h02;
   localparam logic [5:0] FN_ADD = 6'h20;
   localparam logic [5:0] FN_SUB = 6'h22;
   localparam logic [5:0] FN_AND = 6'h24;
   localparam logic [5:0] FN_OR  = 6'h25;
   localparam logic [5:0] FN_XOR = 6'h27;
   localparam logic [5:0] FN_SLT = 6'h2a;

   typedef struct packed {
      logic        executed;
      logic [31:0] next_pc;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        load;        // reg_value comes from the data store read
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
   } exec_result_type;

   typedef struct packed {
      logic                 read_enable;
      logic                 write_enable;
      logic [DSTORE_AW-1:0] index;
      logic [31:0]          write_data;
   } dstore_req_type;

   typedef struct packed {
      logic        enable;
      logic [4:0]  index;
      logic [31:0] data;
   } rf_write_type;

endpackage

// ===== hdl/msec_regfile.sv =====
// 32 x 32 register file, one write port, two registered read ports.
// Per-entry valid bits give all-zero contents after reset. Uses msec_pkg.
module msec_regfile (
   input  logic                  clock,
   input  logic                  reset,
   input  msec_pkg::rf_write_type wr,
   input  logic [4:0]            read_index_a,
   input  logic [4:0]            read_index_b,
   output logic [31:0]           read_data_a,
   output logic [31:0]           read_data_b
);
   import msec_pkg::*;

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] qa_ff, qb_ff;
   logic        va_ff, vb_ff;
   logic        hit_a, hit_b;

   assign hit_a = wr.enable && (wr.index == read_index_a);
   assign hit_b = wr.enable && (wr.index == read_index_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
      end else begin
         if (wr.enable) begin
            valid_ff[wr.index] <= 1'b1;
         end
         va_ff <= hit_a || valid_ff[read_index_a];
         vb_ff <= hit_b || valid_ff[read_index_b];
      end
   end

   // write-first: a read of the entry being written returns the new word
   always_ff @(posedge clock) begin
      if (wr.enable) begin
         mem[wr.index] <= wr.data;
      end
      qa_ff <= hit_a ? wr.data : mem[read_index_a];
      qb_ff <= hit_b ? wr.data : mem[read_index_b];
   end

   assign read_data_a = va_ff ? qa_ff : '0;
   assign read_data_b = vb_ff ? qb_ff : '0;

endmodule

// ===== hdl/msec_dstore.sv =====
// Word data store, single port, registered read data.
// Runs a clearing pass over all DATA_WORDS words after reset. Uses msec_pkg.
module msec_dstore (
   input  logic                    clock,
   input  logic                    reset,
   input  msec_pkg::dstore_req_type req,
   output logic [31:0]             read_data,
   output logic                    ready
);
   import msec_pkg::*;

   logic [31:0]          mem [DATA_WORDS];
   logic [31:0]          read_data_ff;
   logic [DSTORE_AW-1:0] clear_index_ff;
   logic                 clear_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_index_ff <= '0;
         clear_done_ff  <= 1'b0;
      end else if (!clear_done_ff) begin
         clear_index_ff <= clear_index_ff + 1'b1;
         if (clear_index_ff == DSTORE_AW'(DATA_WORDS - 1)) begin
            clear_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!clear_done_ff) begin
         mem[clear_index_ff] <= '0;
      end else if (req.write_enable) begin
         mem[req.index] <= req.write_data;
      end
      if (req.read_enable) begin
         read_data_ff <= mem[req.index];
      end
   end

   assign read_data = read_data_ff;
   assign ready     = clear_done_ff;

endmodule

// ===== hdl/msec_exec.sv =====
// Execute logic: window check, decode, ALU, branch/jump target, store address.
// Purely combinational. Uses msec_pkg.
module msec_exec (
   input  logic [31:0]               instruction,
   input  logic [31:0]               pc,
   input  logic [31:0]               window_base,
   input  logic [31:0]               program_length,
   input  logic [31:0]               operand_a,
   input  logic [31:0]               operand_b,
   output msec_pkg::exec_result_type result,
   output msec_pkg::dstore_req_type  dstore_req
);
   import msec_pkg::*;

   logic [5:0]  op, fn;
   logic [4:0]  rt, rd, sh;
   logic [31:0] imm_sext, imm_zext, eff_addr, pc_plus_one;
   logic [32:0] window_end;
   logic        in_window;
   logic        wr;
   logic [4:0]  dst;
   logic [31:0] val;
   logic        is_load, is_store;
   logic [31:0] npc;

   assign op        = instruction[31:26];
   assign rt        = instruction[20:16];
   assign rd        = instruction[15:11];
   assign sh        = instruction[10:6];
   assign fn        = instruction[5:0];
   assign imm_sext  = {{16{instruction[15]}}, instruction[15:0]};
   assign imm_zext  = {16'h0000, instruction[15:0]};
   assign eff_addr  = operand_a + imm_sext;
   assign pc_plus_one = pc + 32'd1;

   // window test without wrap
   assign window_end = {1'b0, window_base} + {1'b0, program_length};
   assign in_window  = (pc >= window_base) && ({1'b0, pc} < window_end);

   always_comb begin
      wr       = 1'b0;
      dst      = '0;
      val      = '0;
      is_load  = 1'b0;
      is_store = 1'b0;
      npc      = pc_plus_one;
      case (op)
         OP_RTYPE: begin
            dst = rd;
            wr  = 1'b1;
            case (fn)
               FN_AND: val = operand_a & operand_b;
               FN_OR:  val = operand_a | operand_b;
               FN_XOR: val = operand_a ^ operand_b;
               FN_ADD: val = operand_a + operand_b;
               FN_SUB: val = operand_a - operand_b;
               FN_SLL: val = operand_b << sh;
               FN_SRL: val = operand_b >> sh;
               FN_SLT: val = {31'd0, $signed(operand_a) < $signed(operand_b)};
               default: wr = 1'b0;
            endcase
         end
         OP_BEQ: begin
            if (operand_a == operand_b) begin
               npc = pc + imm_sext;
            end
         end
         OP_LW: begin
            dst     = rt;
            wr      = 1'b1;
            is_load = 1'b1;
         end
         OP_SW:   is_store = 1'b1;
         OP_ANDI: begin
            dst = rt;
            wr  = 1'b1;
            val = operand_a & imm_zext;
         end
         OP_ORI: begin
            dst = rt;
            wr  = 1'b1;
            val = operand_a | imm_zext;
         end
         OP_ADDI: begin
            dst = rt;
            wr  = 1'b1;
            val = operand_a + imm_sext;
         end
         OP_J:    npc = {pc[31:26], instruction[25:0]};
         default: ;
      endcase
   end

   always_comb begin
      result = '0;
      result.next_pc = pc;
      if (in_window) begin
         result.executed = 1'b1;
         result.next_pc  = npc;
         // destination zero means no write-back
         if (wr && (dst != 5'd0)) begin
            result.reg_write = 1'b1;
            result.reg_index = dst;
            result.reg_value = is_load ? '0 : val;
            result.load      = is_load;
         end
         if (is_store) begin
            result.mem_write   = 1'b1;
            result.mem_address = eff_addr;
            result.mem_data    = operand_b;
         end
      end
   end

   always_comb begin
      dstore_req.read_enable  = result.load;
      dstore_req.write_enable = result.mem_write;
      dstore_req.index        = eff_addr[DSTORE_AW+1:2];
      dstore_req.write_data   = operand_b;
   end

endmodule

// ===== hdl/mips_subset_execute_core.sv =====
// Top level of the MIPS-subset execute core.
// Instantiates msec_regfile, msec_dstore and msec_exec; uses msec_pkg.
//
// Executes one instruction per clock cycle sustained while the rsp side is not
// stalled: each transaction on the req channel returns one rsp transaction
// through the input register, then the result register, and a dependent
// instruction may follow in the very next cycle because the pending write-back
// in the result register, including load data straight from the data store read
// register, is forwarded into the execute stage. After reset the data store is
// cleared one word per cycle, all DATA_WORDS (1024) words, with req_ready low;
// CSR writes are taken during that pass. A write to the window base register also
// loads the program counter; CSR writes are only to be made while the core is idle.
module mips_subset_execute_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [31:0]                       req_instruction,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_executed,
   output logic [31:0]                       rsp_next_pc,
   output logic                              rsp_reg_write,
   output logic [4:0]                        rsp_reg_index,
   output logic [31:0]                       rsp_reg_value,
   output logic                              rsp_mem_write,
   output logic [31:0]                       rsp_mem_address,
   output logic [31:0]                       rsp_mem_data,
   input  logic                              csr_write_enable,
   input  logic [msec_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_write_data
);
   import msec_pkg::*;

   logic [31:0]     window_base_ff, program_length_ff, pc_ff;
   logic            s1_valid_ff, s1_valid_in;
   logic [31:0]     s1_instr_ff, s1_instr_in;
   logic            s2_valid_ff, s2_valid_in;
   exec_result_type s2_ff;
   exec_result_type exec_out;
   dstore_req_type  exec_dstore_req, dstore_req;
   rf_write_type    rf_write;
   logic [31:0]     rf_a, rf_b, operand_a, operand_b;
   logic [31:0]     dstore_q, s2_wb_value;
   logic            dstore_ready;
   logic            req_accept, s2_open, s1_move;

   assign s2_open    = !s2_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && s2_open;
   assign req_ready  = dstore_ready && (!s1_valid_ff || s1_move);
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_move);
   assign s1_instr_in = req_accept ? req_instruction : s1_instr_ff;
   assign s2_valid_in = s1_move || (s2_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         window_base_ff    <= '0;
         program_length_ff <= '0;
         pc_ff             <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WINDOW_BASE: begin
                  window_base_ff <= csr_write_data;
                  pc_ff          <= csr_write_data;
               end
               CSR_PROGRAM_LENGTH: program_length_ff <= csr_write_data;
               default: ;
            endcase
         end else if (s1_move) begin
            pc_ff <= exec_out.next_pc;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_instr_ff <= s1_instr_in;
      if (s1_move) begin
         s2_ff <= exec_out;
      end
   end

   // result register holds a write-back not yet in the register file
   assign s2_wb_value = s2_ff.load ? dstore_q : s2_ff.reg_value;

   always_comb begin
      operand_a = rf_a;
      operand_b = rf_b;
      if (s2_valid_ff && s2_ff.reg_write) begin
         if (s2_ff.reg_index == s1_instr_ff[25:21]) begin
            operand_a = s2_wb_value;
         end
         if (s2_ff.reg_index == s1_instr_ff[20:16]) begin
            operand_b = s2_wb_value;
         end
      end
   end

   always_comb begin
      rf_write.enable = s2_valid_ff && rsp_ready && s2_ff.reg_write;
      rf_write.index  = s2_ff.reg_index;
      rf_write.data   = s2_wb_value;
   end

   always_comb begin
      dstore_req              = exec_dstore_req;
      dstore_req.read_enable  = s1_move && exec_dstore_req.read_enable;
      dstore_req.write_enable = s1_move && exec_dstore_req.write_enable;
   end

   msec_regfile u_regfile (
      .clock        (clock),
      .reset        (reset),
      .wr           (rf_write),
      .read_index_a (s1_instr_in[25:21]),
      .read_index_b (s1_instr_in[20:16]),
      .read_data_a  (rf_a),
      .read_data_b  (rf_b)
   );

   msec_dstore u_dstore (
      .clock     (clock),
      .reset     (reset),
      .req       (dstore_req),
      .read_data (dstore_q),
      .ready     (dstore_ready)
   );

   msec_exec u_exec (
      .instruction    (s1_instr_ff),
      .pc             (pc_ff),
      .window_base    (window_base_ff),
      .program_length (program_length_ff),
      .operand_a      (operand_a),
      .operand_b      (operand_b),
      .result         (exec_out),
      .dstore_req     (exec_dstore_req)
   );

   assign rsp_valid       = s2_valid_ff;
   assign rsp_executed    = s2_ff.executed;
   assign rsp_next_pc     = s2_ff.next_pc;
   assign rsp_reg_write   = s2_ff.reg_write;
   assign rsp_reg_index   = s2_ff.reg_index;
   assign rsp_reg_value   = s2_wb_value;
   assign rsp_mem_write   = s2_ff.mem_write;
   assign rsp_mem_address = s2_ff.mem_address;
   assign rsp_mem_data    = s2_ff.mem_data;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !dstore_ready |-> !req_ready)
      else $error("transaction accepted during data store clear");

   a_pc_follows_result: assert property (@(posedge clock) disable iff (reset)
      (s1_move && !csr_write_enable) |=> (pc_ff == s2_ff.next_pc))
      else $error("program counter differs from reported next_pc");

   a_skipped_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_executed) |->
         (!rsp_reg_write && !rsp_mem_write && rsp_reg_value == 32'd0 &&
          rsp_mem_address == 32'd0 && rsp_mem_data == 32'd0))
      else $error("skipped instruction reports side effects");

   a_no_write_to_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reg_write) |-> (rsp_reg_index != 5'd0 && !rsp_mem_write))
      else $error("bad write-back report");

endmodule

// ===== test/msec_exec_check.sv =====
// Transaction checker for the MIPS-subset execute core.
// Tracks register file, data store, program counter and window; compares each result.
// Depends on msec_pkg.
module msec_exec_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [31:0]                       req_instruction,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_executed,
   input  logic [31:0]                       rsp_next_pc,
   input  logic                              rsp_reg_write,
   input  logic [4:0]                        rsp_reg_index,
   input  logic [31:0]                       rsp_reg_value,
   input  logic                              rsp_mem_write,
   input  logic [31:0]                       rsp_mem_address,
   input  logic [31:0]                       rsp_mem_data,
   input  logic                              csr_write_enable,
   input  logic [msec_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_write_data,
   output int                                results_done,
   output int                                mismatches
);
   timeunit 1ns;
   timeprecision 1ps;
   import msec_pkg::*;

   typedef struct packed {
      logic        executed;
      logic [31:0] next_pc;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
   } outcome_type;

   logic [31:0] gpr [32];
   logic [31:0] data_words [DATA_WORDS];
   logic [31:0] prog_counter;
   logic [31:0] win_start;
   logic [31:0] win_length;
   outcome_type expected_q [$];

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      mismatches++;
   endtask

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Runs one instruction against the shadow state and returns what the core must report.
   function automatic outcome_type execute_item(input logic [31:0] word);
      outcome_type o;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [15:0] imm;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] npc;
      logic [31:0] val;
      logic [31:0] addr;
      logic [4:0]  dst;
      logic        wr;
      logic [32:0] lo;
      logic [32:0] hi;
      o  = '0;
      lo = {1'b0, win_start};
      hi = lo + {1'b0, win_length};
      if (!({1'b0, prog_counter} >= lo && {1'b0, prog_counter} < hi)) begin
         o.next_pc = prog_counter;
         return o;
      end
      op  = word[31:26];
      rs  = word[25:21];
      rt  = word[20:16];
      rd  = word[15:11];
      sh  = word[10:6];
      fn  = word[5:0];
      imm = word[15:0];
      a   = gpr[rs];
      b   = gpr[rt];
      npc = prog_counter + 32'd1;
      wr  = 1'b0;
      dst = '0;
      val = '0;
      case (op)
         OP_RTYPE: begin
            dst = rd;
            wr  = 1'b1;
            case (fn)
               FN_AND:  val = a & b;
               FN_OR:   val = a | b;
               FN_XOR:  val = a ^ b;
               FN_ADD:  val = a + b;
               FN_SUB:  val = a - b;
               FN_SLL:  val = b << sh;
               FN_SRL:  val = b >> sh;
               FN_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               default: wr = 1'b0;
            endcase
         end
         OP_BEQ: begin
            if (a == b) npc = prog_counter + sext16(imm);
         end
         OP_LW: begin
            dst  = rt;
            wr   = 1'b1;
            addr = a + sext16(imm);
            val  = data_words[addr[DSTORE_AW+1:2]];
         end
         OP_SW: begin
            addr          = a + sext16(imm);
            o.mem_write   = 1'b1;
            o.mem_address = addr;
            o.mem_data    = b;
            data_words[addr[DSTORE_AW+1:2]] = b;
         end
         OP_ANDI: begin
            dst = rt;
            wr  = 1'b1;
            val = a & {16'h0000, imm};
         end
         OP_ORI: begin
            dst = rt;
            wr  = 1'b1;
            val = a | {16'h0000, imm};
         end
         OP_ADDI: begin
            dst = rt;
            wr  = 1'b1;
            val = a + sext16(imm);
         end
         OP_J: begin
            npc = {prog_counter[31:26], word[25:0]};
         end
         default: ;
      endcase
      if (wr && dst != 5'd0) begin
         gpr[dst]    = val;
         o.reg_write = 1'b1;
         o.reg_index = dst;
         o.reg_value = val;
      end
      prog_counter = npc;
      o.executed   = 1'b1;
      o.next_pc    = npc;
      return o;
   endfunction

   always @(posedge clock) begin : watch
      int          i;
      outcome_type want;
      if (reset) begin
         for (i = 0; i < 32; i++) gpr[i] = '0;
         for (i = 0; i < DATA_WORDS; i++) data_words[i] = '0;
         prog_counter = '0;
         win_start    = '0;
         win_length   = '0;
         mismatches   = 0;
         expected_q.delete();
         results_done <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WINDOW_BASE: begin
                  win_start    = csr_write_data;
                  prog_counter = csr_write_data;
               end
               CSR_PROGRAM_LENGTH: win_length = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results_done <= results_done + 1;
            if (expected_q.size() == 0) begin
               report("unexpected result, next_pc", 32'h0, rsp_next_pc);
            end else begin
               want = expected_q.pop_front();
               if (rsp_executed !== want.executed)
                  report("executed", 32'(want.executed), 32'(rsp_executed));
               if (rsp_next_pc !== want.next_pc)
                  report("next_pc", want.next_pc, rsp_next_pc);
               if (rsp_reg_write !== want.reg_write)
                  report("reg_write", 32'(want.reg_write), 32'(rsp_reg_write));
               if (rsp_reg_index !== want.reg_index)
                  report("reg_index", 32'(want.reg_index), 32'(rsp_reg_index));
               if (rsp_reg_value !== want.reg_value)
                  report("reg_value", want.reg_value, rsp_reg_value);
               if (rsp_mem_write !== want.mem_write)
                  report("mem_write", 32'(want.mem_write), 32'(rsp_mem_write));
               if (rsp_mem_address !== want.mem_address)
                  report("mem_address", want.mem_address, rsp_mem_address);
               if (rsp_mem_data !== want.mem_data)
                  report("mem_data", want.mem_data, rsp_mem_data);
            end
         end
         if (req_valid && req_ready)
            expected_q.insert(expected_q.size(), execute_item(req_instruction));
      end
   end

endmodule

// ===== test/mips_subset_execute_core_tb.sv =====
// Top of the execute core testbench: clock, reset, CSR setup and instruction traffic.
// Directed instruction sequences, then random programs under several program windows.
// Depends on msec_pkg, mips_subset_execute_core and msec_exec_check.
module mips_subset_execute_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import msec_pkg::*;

   localparam int         IDLE_LIMIT = 4000;
   localparam logic [5:0] OP_UNUSED  = 6'h3f;
   localparam logic [5:0] FN_UNUSED  = 6'h3f;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [31:0]            req_instruction;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_executed;
   logic [31:0]            rsp_next_pc;
   logic                   rsp_reg_write;
   logic [4:0]             rsp_reg_index;
   logic [31:0]            rsp_reg_value;
   logic                   rsp_mem_write;
   logic [31:0]            rsp_mem_address;
   logic [31:0]            rsp_mem_data;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_write_data;

   int results_done;
   int mismatches;
   int items_sent  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   bit hold_done   = 1'b0;

   mips_subset_execute_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instruction  (req_instruction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_executed     (rsp_executed),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_reg_write    (rsp_reg_write),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_mem_data     (rsp_mem_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   msec_exec_check exec_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instruction  (req_instruction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_executed     (rsp_executed),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_reg_write    (rsp_reg_write),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_mem_data     (rsp_mem_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .results_done     (results_done),
      .mismatches       (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rtype(input logic [5:0] fn, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [4:0] rd,
                                         input logic [4:0] sh);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] jtype(input logic [25:0] target);
      return {OP_J, target};
   endfunction

   // Mostly low registers so that results feed the next instructions.
   function automatic logic [4:0] pick_reg();
      logic [4:0] r;
      if ($urandom_range(0, 4) != 0) r = 5'($urandom_range(0, 7));
      else r = 5'($urandom_range(0, 31));
      return r;
   endfunction

   function automatic logic [15:0] pick_imm();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0:       v = 16'h0000;
         1:       v = 16'hffff;
         2:       v = 16'h7fff;
         3:       v = 16'h8000;
         default: v = 16'($urandom_range(0, 16'hffff));
      endcase
      return v;
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [15:0] offset;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         case ($urandom_range(0, 7))
            0:       fn = FN_AND;
            1:       fn = FN_OR;
            2:       fn = FN_XOR;
            3:       fn = FN_ADD;
            4:       fn = FN_SUB;
            5:       fn = FN_SLL;
            6:       fn = FN_SRL;
            default: fn = FN_SLT;
         endcase
         return rtype(fn, pick_reg(), pick_reg(), pick_reg(), 5'($urandom_range(0, 31)));
      end
      if (pick < 48) begin
         fn = 6'($urandom_range(0, 63));
         return rtype(fn, pick_reg(), pick_reg(), pick_reg(), 5'($urandom_range(0, 31)));
      end
      if (pick < 60) begin
         case ($urandom_range(0, 2))
            0:       op = OP_ADDI;
            1:       op = OP_ANDI;
            default: op = OP_ORI;
         endcase
         return itype(op, pick_reg(), pick_reg(), pick_imm());
      end
      if (pick < 76) begin
         // small offsets so that loads hit earlier stores
         case ($urandom_range(0, 3))
            0:       offset = 16'h0000;
            1:       offset = 16'h0004;
            2:       offset = 16'hfffc;
            default: offset = pick_imm();
         endcase
         op = (pick < 68) ? OP_LW : OP_SW;
         return itype(op, pick_reg(), pick_reg(), offset);
      end
      if (pick < 84) begin
         if ($urandom_range(0, 3) == 0) offset = pick_imm();
         else offset = 16'($urandom_range(0, 16) - 8);
         return itype(OP_BEQ, pick_reg(), pick_reg(), offset);
      end
      // jump targets stay clear of the 64M block edges so the pc keeps inside the window
      if (pick < 88) return jtype(26'($urandom_range(26'h0100000, 26'h3efffff)));
      if (pick < 92) begin
         op = 6'($urandom_range(0, 63));
         if (op inside {OP_RTYPE, OP_J, OP_BEQ, OP_ADDI,
                        OP_ANDI, OP_ORI, OP_LW, OP_SW}) op = OP_UNUSED;
         return {op, 26'($urandom())};
      end
      return $urandom();
   endfunction

   task automatic send(input logic [31:0] word);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_instruction <= word;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (results_done != items_sent) @(posedge clock);
   endtask

   task automatic program_window(input logic [31:0] start, input logic [31:0] length);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_WINDOW_BASE;
      csr_write_data   <= start;
      @(posedge clock);
      csr_index        <= CSR_PROGRAM_LENGTH;
      csr_write_data   <= length;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_program(input int count);
      // land in the middle of the current 64M block first
      send(jtype(26'h2000000));
      repeat (count - 1) send(random_instruction());
   endtask

   // Receiver: changing ready patterns, plus one long hold-off to back up the core.
   initial begin : receiver
      int   mode;
      int   mode_left;
      logic r;
      rsp_ready <= 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= 200) begin
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            case (mode)
               0:       r = 1'b1;
               1:       r = $urandom_range(0, 1);
               2:       r = ($urandom_range(0, 3) == 0);
               default: r = ~rsp_ready;
            endcase
            rsp_ready <= r;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_instruction  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_WINDOW_BASE;
      csr_write_data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset window is empty: nothing executes
      send(itype(OP_ADDI, 5'd0, 5'd1, 16'h0005));
      send(itype(OP_SW, 5'd0, 5'd1, 16'h0000));
      wait_drained();

      program_window(32'd16, 32'd32);
      send(itype(OP_ADDI, 5'd0, 5'd1, 16'h7fff));
      send(itype(OP_ADDI, 5'd0, 5'd2, 16'h8000));
      send(itype(OP_ORI, 5'd0, 5'd3, 16'hffff));
      send(itype(OP_ANDI, 5'd2, 5'd4, 16'hffff));
      send(rtype(FN_SLL, 5'd0, 5'd3, 5'd13, 5'd16));
      send(rtype(FN_OR, 5'd13, 5'd3, 5'd13, 5'd0));
      send(rtype(FN_ADD, 5'd13, 5'd13, 5'd14, 5'd0));
      send(rtype(FN_SUB, 5'd0, 5'd1, 5'd5, 5'd0));
      send(rtype(FN_AND, 5'd2, 5'd13, 5'd6, 5'd0));
      send(rtype(FN_XOR, 5'd2, 5'd1, 5'd7, 5'd0));
      send(rtype(FN_SRL, 5'd0, 5'd13, 5'd8, 5'd31));
      send(rtype(FN_SLL, 5'd0, 5'd1, 5'd9, 5'd31));
      send(rtype(FN_SLT, 5'd2, 5'd1, 5'd10, 5'd0));
      send(rtype(FN_SLT, 5'd1, 5'd2, 5'd11, 5'd0));
      send(itype(OP_SW, 5'd1, 5'd13, 16'hfffc));
      send(itype(OP_LW, 5'd1, 5'd12, 16'hfffc));
      send(itype(OP_LW, 5'd0, 5'd15, 16'h8000));
      send(itype(OP_ADDI, 5'd1, 5'd0, 16'h0001));
      send(rtype(FN_UNUSED, 5'd1, 5'd2, 5'd16, 5'd0));
      send({OP_UNUSED, 26'h3ffffff});
      send(itype(OP_BEQ, 5'd1, 5'd2, 16'h0005));
      send(itype(OP_BEQ, 5'd0, 5'd0, 16'hfffd));
      send(jtype(26'h0000014));
      send(jtype(26'h0000100));
      send(itype(OP_ADDI, 5'd0, 5'd1, 16'h0001));
      wait_drained();

      // single-word window at the top of the address space; pc wraps out of it
      program_window(32'hffff_ffff, 32'hffff_ffff);
      send(itype(OP_ADDI, 5'd0, 5'd17, 16'hffff));
      send(rtype(FN_ADD, 5'd17, 5'd17, 5'd18, 5'd0));
      send(rtype(FN_ADD, 5'd17, 5'd17, 5'd18, 5'd0));
      wait_drained();

      program_window(32'h0000_0000, 32'hffff_ffff);
      random_program(600);
      wait_drained();

      program_window(32'h8000_0000, 32'h8000_0000);
      random_program(400);
      wait_drained();

      program_window({6'($urandom_range(0, 63)), 26'h0}, 32'h0400_0000);
      random_program(450);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
